// ===== hdl/prrc_pkg.sv =====
// ----------------------------------------------------------------------------
// prrc_pkg
// Types and constants shared by the page release range coalescer.
// ----------------------------------------------------------------------------
package prrc_pkg;

  // field widths
  localparam int BLOCK_W = 2;
  localparam int PAGE_W  = 32;
  localparam int COUNT_W = 33;
  localparam int BATCH_W = 17;
  localparam int CFG_W   = 32;

  // configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int REG_BATCH  = 0;
  localparam int REG_BLOCK0 = 1;

  localparam logic [BATCH_W-1:0] BATCH_RESET = 17'd4096;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // back end sequencer codes
  localparam logic ST_TAKE  = 1'b0;
  localparam logic ST_CHECK = 1'b1;

  // request word
  typedef struct packed {
    logic               mode;
    logic [BLOCK_W-1:0] block_id;
    logic [PAGE_W-1:0]  first_page;
    logic [PAGE_W-1:0]  page_count;
  } in_t;

  // release result word
  typedef struct packed {
    logic [BLOCK_W-1:0] out_block;
    logic [PAGE_W-1:0]  out_start;
    logic [COUNT_W-1:0] out_count;
    logic               status;
    logic               last;
  } out_t;

  // classified command
  typedef struct packed {
    logic               flush;
    logic [BLOCK_W-1:0] block;
    logic [PAGE_W-1:0]  first;
    logic [PAGE_W-1:0]  count;
  } cmd_t;

endpackage

// ===== hdl/prrc_front.sv =====
// ----------------------------------------------------------------------------
// prrc_front
// Accepts request words, drops empty requests and registers the command.
// ----------------------------------------------------------------------------
module prrc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  prrc_pkg::in_t   req,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output prrc_pkg::cmd_t  cmd
);
  import prrc_pkg::*;

  logic keep;
  logic take;

  // a flush always passes, a release only with a nonzero count
  assign keep      = req.mode || (req.page_count != '0);
  assign req_ready = !cmd_valid || cmd_ready;
  assign take      = req_valid && req_ready;

  // command valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (take) begin
      cmd.flush <= req.mode;
      cmd.block <= req.block_id;
      cmd.first <= req.first_page;
      cmd.count <= req.page_count;
    end
  end

endmodule

// ===== hdl/prrc_queue.sv =====
// ----------------------------------------------------------------------------
// prrc_queue
// Short command queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module prrc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  prrc_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            pop_valid,
  output prrc_pkg::cmd_t  pop_cmd
);
  import prrc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/prrc_back.sv =====
// ----------------------------------------------------------------------------
// prrc_back
// Holds the pending run, merges or replaces it, range checks emitted runs
// and drives the registered result word.
// ----------------------------------------------------------------------------
module prrc_back #(
  parameter int BLOCK_COUNT = 4
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cmd_valid,
  output logic                                       cmd_pop,
  input  prrc_pkg::cmd_t                             cmd,
  input  logic [prrc_pkg::BATCH_W-1:0]               batch_pages,
  input  logic [BLOCK_COUNT-1:0][prrc_pkg::PAGE_W-1:0] block_pages,
  output logic                                       rel_valid,
  input  logic                                       rel_ready,
  output prrc_pkg::out_t                             rel
);
  import prrc_pkg::*;

  logic               step;
  logic               step_next;
  logic               run_valid;
  logic [BLOCK_W-1:0] run_block;
  logic [PAGE_W-1:0]  run_start;
  logic [COUNT_W-1:0] run_count;
  logic [PAGE_W+1:0]  run_end;

  logic               out_free;
  logic               merge_hit;
  logic               new_hits_batch;
  logic               run_hits_batch;
  logic [PAGE_W+1:0]  end_sum;
  logic [PAGE_W-1:0]  pages;
  logic               blk_ok;
  logic               run_bad;
  logic               emit;
  logic               emit_last;
  logic               run_load;
  logic               run_merge;
  logic               run_clear;

  assign out_free       = !rel_valid || rel_ready;
  assign merge_hit      = run_valid && (run_block == cmd.block) &&
                          (run_end == {2'b00, cmd.first});
  assign new_hits_batch = cmd.count >= PAGE_W'(batch_pages);
  assign run_hits_batch = run_count >= COUNT_W'(batch_pages);
  assign end_sum        = {2'b00, cmd.first} + {2'b00, cmd.count};

  // range check of the pending run against its block size
  always_comb begin
    pages  = '0;
    blk_ok = 1'b0;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      if (int'(run_block) == i) begin
        pages  = block_pages[i];
        blk_ok = 1'b1;
      end
    end
    run_bad = !blk_ok || (pages == '0) || (run_start >= pages) ||
              (run_count > {1'b0, pages - run_start});
  end

  // step decode: take a command, then a threshold check for releases
  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    run_load  = 1'b0;
    run_merge = 1'b0;
    run_clear = 1'b0;
    step_next = step;
    unique case (step)
      ST_TAKE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (cmd.flush) begin
            emit      = run_valid;
            emit_last = 1'b1;
            run_clear = 1'b1;
          end else if (merge_hit) begin
            run_merge = 1'b1;
            step_next = ST_CHECK;
          end else begin
            emit      = run_valid;
            emit_last = run_bad || !new_hits_batch;
            if (run_valid && run_bad) begin
              run_clear = 1'b1;
            end else begin
              run_load  = 1'b1;
              step_next = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (out_free) begin
          step_next = ST_TAKE;
          if (run_hits_batch) begin
            emit      = run_valid;
            emit_last = 1'b1;
            run_clear = 1'b1;
          end
        end
      end
      default: begin
        step_next = ST_TAKE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_TAKE;
      run_valid <= 1'b0;
      rel_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (run_clear) begin
        run_valid <= 1'b0;
      end else if (run_load) begin
        run_valid <= 1'b1;
      end
      if (emit) begin
        rel_valid <= 1'b1;
      end else if (rel_ready) begin
        rel_valid <= 1'b0;
      end
    end
  end

  // run and result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      rel.out_block <= run_block;
      rel.out_start <= run_start;
      rel.out_count <= run_count;
      rel.status    <= run_bad;
      rel.last      <= emit_last;
    end
    if (run_load) begin
      run_block <= cmd.block;
      run_start <= cmd.first;
      run_count <= {1'b0, cmd.count};
      run_end   <= end_sum;
    end else if (run_merge) begin
      run_count <= run_count + {1'b0, cmd.count};
      run_end   <= end_sum;
    end
  end

endmodule

// ===== hdl/page_release_range_coalescer_core.sv =====
// ----------------------------------------------------------------------------
// page_release_range_coalescer_core
// Coalesces page release requests into runs and emits range checked runs.
// Requests are registered in the front end and held in the command queue; a
// later command or the threshold check emits the pending run into the result.
// One flush per cycle while the result word is free; a release that loads or
// merges the run passes the take and threshold check steps of the sequencer.
// Reset: synchronous; clears the pending run and queue, batch size to 4096.
// ----------------------------------------------------------------------------
module page_release_range_coalescer_core #(
  parameter int BLOCK_COUNT = 4
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         req_valid,
  output logic                                         req_ready,
  input  prrc_pkg::in_t                                req,
  output logic                                         rel_valid,
  input  logic                                         rel_ready,
  output prrc_pkg::out_t                               rel,
  input  logic                                         cfg_write,
  input  logic [prrc_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [prrc_pkg::CFG_W-1:0]                   cfg_data
);
  import prrc_pkg::*;

  logic [BATCH_W-1:0]                  batch_pages;
  logic [BLOCK_COUNT-1:0][PAGE_W-1:0]  block_pages;

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_pages <= BATCH_RESET;
      block_pages <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_IDX_W'(REG_BATCH)) begin
        batch_pages <= cfg_data[BATCH_W-1:0];
      end
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        if (int'(cfg_index) == REG_BLOCK0 + i) begin
          block_pages[i] <= cfg_data[PAGE_W-1:0];
        end
      end
    end
  end

  // request classification
  prrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  // command queue
  prrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd)
  );

  // run coalescing and result generation
  prrc_back #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .cmd         (q_cmd),
    .batch_pages (batch_pages),
    .block_pages (block_pages),
    .rel_valid   (rel_valid),
    .rel_ready   (rel_ready),
    .rel         (rel)
  );

endmodule
